// ----- rtl/core/fes_pkg.sv -----
package fes_pkg;

    localparam int DistW   = 16;
    localparam int XW      = 10;          // clamped distance, 0..999
    localparam int NumSets = 3;
    localparam int NumRules = NumSets * NumSets;
    localparam int MemW    = 16;          // Q1.15 membership, 32768 = 1.0
    localparam int OffW    = 7;           // offset into a 100 mm edge
    localparam int SumW    = 19;          // strength sums, up to 9 * 1.0
    localparam int PW      = 20;          // sum of strength * (set index + 1)
    localparam int NumW    = 26;          // 50 * PW value
    localparam int SpeedW  = 8;

    localparam logic [XW-1:0]   DistClamp    = 10'd999;
    localparam logic [MemW-1:0] QOne         = 16'd32768;
    localparam logic [SpeedW-1:0] DefaultSpeed = 8'd100;

    // Every sloped edge spans 100 mm: off * 32768 / 100 = off * 8192 / 25.
    // ceil(2^25 / 25) with the 2^13 factor folded in; exact for off < 100.
    localparam int RecipW     = 21;
    localparam int RecipShift = 12;
    localparam logic [RecipW-1:0] EdgeRecip = 21'd1342178;

    typedef logic [XW-1:0]   t_dist;
    typedef logic [MemW-1:0] t_mem;

    typedef enum logic [1:0] {
        MB_ZERO,
        MB_ONE,
        MB_EDGE
    } t_mb_kind;

    typedef enum logic [1:0] {
        SPD_SLOW,
        SPD_NORM,
        SPD_FAST
    } t_speed_set;

    typedef struct packed {
        t_dist a;
        t_dist b;
        t_dist c;
        t_dist d;
    } t_trap;

    // close, ok, far
    localparam t_trap SetTrap [NumSets] = '{
        '{10'd0,   10'd0,   10'd400,  10'd500},
        '{10'd450, 10'd550, 10'd650,  10'd750},
        '{10'd600, 10'd700, 10'd1000, 10'd1000}
    };

    // [front set][back set]
    localparam t_speed_set RuleRight [NumSets][NumSets] = '{
        '{SPD_FAST, SPD_FAST, SPD_FAST},
        '{SPD_NORM, SPD_NORM, SPD_NORM},
        '{SPD_SLOW, SPD_NORM, SPD_NORM}
    };
    localparam t_speed_set RuleLeft [NumSets][NumSets] = '{
        '{SPD_NORM, SPD_NORM, SPD_SLOW},
        '{SPD_FAST, SPD_NORM, SPD_SLOW},
        '{SPD_FAST, SPD_FAST, SPD_NORM}
    };

    typedef struct packed {
        t_mb_kind            kind;
        logic [OffW-1:0]     off;
    } t_mb_code;

    typedef struct packed {
        t_mb_code [NumSets-1:0] front;
        t_mb_code [NumSets-1:0] back;
    } t_fz;

    typedef struct packed {
        t_mem [NumSets-1:0] front;
        t_mem [NumSets-1:0] back;
    } t_mbs;

    typedef struct packed {
        t_mem [NumRules-1:0] w;
    } t_str;

    typedef struct packed {
        logic [NumSets-1:0][SumW-1:0] w;
        logic [NumSets-1:0][SumW-1:0] pl;
        logic [NumSets-1:0][SumW-1:0] pr;
    } t_row;

    typedef struct packed {
        logic [SumW-1:0] w;
        logic [PW-1:0]   pl;
        logic [PW-1:0]   pr;
    } t_tot;

    typedef struct packed {
        logic [NumW-1:0]   rem_l;
        logic [NumW-1:0]   rem_r;
        logic [SumW-1:0]   w;
        logic [SpeedW-1:0] q_l;
        logic [SpeedW-1:0] q_r;
        logic              none;
    } t_div;

    function automatic t_dist clamp_dist(input logic [DistW-1:0] v);
        t_dist r;
        if (v > DistW'(DistClamp)) begin
            r = DistClamp;
        end else begin
            r = v[XW-1:0];
        end
        return r;
    endfunction

    function automatic t_mb_code classify(input t_dist x, input t_trap s);
        t_mb_code r;
        r.kind = MB_ZERO;
        r.off  = '0;
        if (x < s.a || x > s.d) begin
            r.kind = MB_ZERO;
        end else if (x < s.b) begin
            r.kind = MB_EDGE;
            r.off  = OffW'(x - s.a);
        end else if (x <= s.c) begin
            r.kind = MB_ONE;
        end else begin
            r.kind = MB_EDGE;
            r.off  = OffW'(s.d - x);
        end
        return r;
    endfunction

    function automatic t_mem edge_value(input logic [OffW-1:0] off);
        logic [OffW+RecipW-1:0] p;
        p = (OffW+RecipW)'(off) * (OffW+RecipW)'(EdgeRecip);
        return p[RecipShift +: MemW];
    endfunction

    // strength times (set index + 1); the center is 50 times that
    function automatic logic [SumW-1:0] weigh(input t_mem w, input t_speed_set s);
        logic [SumW-1:0] r;
        case (s)
            SPD_SLOW: r = SumW'(w);
            SPD_NORM: r = SumW'(w) << 1;
            SPD_FAST: r = (SumW'(w) << 1) + SumW'(w);
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/fes_fuzzify.sv -----
module fes_fuzzify (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [fes_pkg::DistW-1:0]  i_front,
    input  logic [fes_pkg::DistW-1:0]  i_back,
    output logic                       o_valid,
    input  logic                       i_ready,
    output fes_pkg::t_mbs              o_mbs
);

    logic          r_a_valid;
    fes_pkg::t_fz  r_a;
    fes_pkg::t_fz  n_a;
    logic          r_b_valid;
    fes_pkg::t_mbs r_b;
    fes_pkg::t_mbs n_b;
    logic          a_ready;
    logic          b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // stage A: clamp and locate each distance on each trapezoid
    always_comb begin
        fes_pkg::t_dist f;
        fes_pkg::t_dist b;
        f = fes_pkg::clamp_dist(i_front);
        b = fes_pkg::clamp_dist(i_back);
        for (int j = 0; j < fes_pkg::NumSets; j++) begin
            n_a.front[j] = fes_pkg::classify(f, fes_pkg::SetTrap[j]);
            n_a.back[j]  = fes_pkg::classify(b, fes_pkg::SetTrap[j]);
        end
    end

    // stage B: membership values
    always_comb begin
        for (int j = 0; j < fes_pkg::NumSets; j++) begin
            case (r_a.front[j].kind)
                fes_pkg::MB_ONE:  n_b.front[j] = fes_pkg::QOne;
                fes_pkg::MB_EDGE: n_b.front[j] = fes_pkg::edge_value(r_a.front[j].off);
                default:          n_b.front[j] = '0;
            endcase
            case (r_a.back[j].kind)
                fes_pkg::MB_ONE:  n_b.back[j] = fes_pkg::QOne;
                fes_pkg::MB_EDGE: n_b.back[j] = fes_pkg::edge_value(r_a.back[j].off);
                default:          n_b.back[j] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a <= n_a;
        end
        if (b_ready) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_mbs   = r_b;

endmodule

// ----- rtl/core/fes_rules.sv -----
module fes_rules (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fes_pkg::t_mbs  i_mbs,
    output logic           o_valid,
    input  logic           i_ready,
    output fes_pkg::t_div  o_div
);

    localparam int NumStages = 4;

    logic [NumStages-1:0] r_valid;
    logic [NumStages-1:0] stage_ready;

    fes_pkg::t_str r_str;
    fes_pkg::t_str n_str;
    fes_pkg::t_row r_row;
    fes_pkg::t_row n_row;
    fes_pkg::t_tot r_tot;
    fes_pkg::t_tot n_tot;
    fes_pkg::t_div r_div;
    fes_pkg::t_div n_div;

    always_comb begin
        stage_ready[NumStages-1] = !r_valid[NumStages-1] || i_ready;
        for (int s = NumStages - 2; s >= 0; s--) begin
            stage_ready[s] = !r_valid[s] || stage_ready[s+1];
        end
    end

    assign o_ready = stage_ready[0];

    // firing strength = min(front, back)
    always_comb begin
        for (int j = 0; j < fes_pkg::NumSets; j++) begin
            for (int k = 0; k < fes_pkg::NumSets; k++) begin
                n_str.w[j*fes_pkg::NumSets+k] =
                    (i_mbs.front[j] < i_mbs.back[k]) ? i_mbs.front[j] : i_mbs.back[k];
            end
        end
    end

    // per front-set partial sums
    always_comb begin
        fes_pkg::t_mem w;
        for (int j = 0; j < fes_pkg::NumSets; j++) begin
            n_row.w[j]  = '0;
            n_row.pl[j] = '0;
            n_row.pr[j] = '0;
            for (int k = 0; k < fes_pkg::NumSets; k++) begin
                w = r_str.w[j*fes_pkg::NumSets+k];
                n_row.w[j]  = n_row.w[j] + fes_pkg::SumW'(w);
                n_row.pl[j] = n_row.pl[j] + fes_pkg::weigh(w, fes_pkg::RuleLeft[j][k]);
                n_row.pr[j] = n_row.pr[j] + fes_pkg::weigh(w, fes_pkg::RuleRight[j][k]);
            end
        end
    end

    always_comb begin
        n_tot.w  = '0;
        n_tot.pl = '0;
        n_tot.pr = '0;
        for (int j = 0; j < fes_pkg::NumSets; j++) begin
            n_tot.w  = n_tot.w + r_row.w[j];
            n_tot.pl = n_tot.pl + fes_pkg::PW'(r_row.pl[j]);
            n_tot.pr = n_tot.pr + fes_pkg::PW'(r_row.pr[j]);
        end
    end

    // numerators: 50 * p = 32p + 16p + 2p
    always_comb begin
        logic [fes_pkg::NumW-1:0] pl;
        logic [fes_pkg::NumW-1:0] pr;
        pl = fes_pkg::NumW'(r_tot.pl);
        pr = fes_pkg::NumW'(r_tot.pr);
        n_div.rem_l = (pl << 5) + (pl << 4) + (pl << 1);
        n_div.rem_r = (pr << 5) + (pr << 4) + (pr << 1);
        n_div.w     = r_tot.w;
        n_div.q_l   = '0;
        n_div.q_r   = '0;
        n_div.none  = (r_tot.w == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s < NumStages; s++) begin
                if (stage_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready[0]) begin
            r_str <= n_str;
        end
        if (stage_ready[1]) begin
            r_row <= n_row;
        end
        if (stage_ready[2]) begin
            r_tot <= n_tot;
        end
        if (stage_ready[3]) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid[NumStages-1];
    assign o_div   = r_div;

endmodule

// ----- rtl/core/fes_div_step.sv -----
// One restoring-division step: resolves quotient bit Bit of both speeds.
module fes_div_step #(
    parameter int Bit = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fes_pkg::t_div  i_div,
    output logic           o_valid,
    input  logic           i_ready,
    output fes_pkg::t_div  o_div
);

    logic          r_valid;
    fes_pkg::t_div r_div;
    fes_pkg::t_div n_div;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        logic [fes_pkg::NumW:0] dvs;
        logic [fes_pkg::NumW:0] rl;
        logic [fes_pkg::NumW:0] rr;
        n_div = i_div;
        dvs   = (fes_pkg::NumW+1)'(i_div.w) << Bit;
        rl    = {1'b0, i_div.rem_l};
        rr    = {1'b0, i_div.rem_r};
        if (rl >= dvs) begin
            n_div.rem_l    = fes_pkg::NumW'(rl - dvs);
            n_div.q_l[Bit] = 1'b1;
        end
        if (rr >= dvs) begin
            n_div.rem_r    = fes_pkg::NumW'(rr - dvs);
            n_div.q_r[Bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

// ----- rtl/core/fuzzy_edge_follow_speed.sv -----
// Channel    Dir  Beat contents
// s_axis     in   tdata[15:0] front_distance, tdata[31:16] back_distance
// m_axis     out  tdata[7:0] left_speed, tdata[15:8] right_speed, tuser no_rule_fired
//
// One beat in per cycle unless the output stalls, one beat out per input beat; the
// stages are 2 fuzzify, 4 rule evaluation, 8 quotient-bit steps of the divider, 1 output reg.
// The divider is pipelined per quotient bit, so it takes one pair per cycle when not stalled.
// Reset clears only the stage valid bits; no state carries between beats.
// Each stage holds while full and its successor cannot take data, so bubbles collapse
// and a stalled output still lets upstream stages fill.
module fuzzy_edge_follow_speed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // front_distance, back_distance
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // left_speed, right_speed
    output logic        o_m_axis_tuser    // no_rule_fired
);

    localparam int NumSteps = fes_pkg::SpeedW;

    logic          fz_valid;
    logic          fz_ready;
    fes_pkg::t_mbs fz_mbs;

    logic          div_valid [NumSteps+1];
    logic          div_ready [NumSteps+1];
    fes_pkg::t_div div_data  [NumSteps+1];

    logic                        r_out_valid;
    logic [fes_pkg::SpeedW-1:0]  r_out_left;
    logic [fes_pkg::SpeedW-1:0]  r_out_right;
    logic                        r_out_none;
    logic                        out_ready;

    fes_fuzzify u_fuzzify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_front (i_s_axis_tdata[15:0]),
        .i_back  (i_s_axis_tdata[31:16]),
        .o_valid (fz_valid),
        .i_ready (fz_ready),
        .o_mbs   (fz_mbs)
    );

    fes_rules u_rules (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fz_valid),
        .o_ready (fz_ready),
        .i_mbs   (fz_mbs),
        .o_valid (div_valid[0]),
        .i_ready (div_ready[0]),
        .o_div   (div_data[0])
    );

    // quotient < 256 since every center is at most 150; MSB first
    for (genvar g = 0; g < NumSteps; g++) begin : g_div
        fes_div_step #(
            .Bit (NumSteps - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_div   (div_data[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_div   (div_data[g+1])
        );
    end

    assign out_ready           = !r_out_valid || i_m_axis_tready;
    assign div_ready[NumSteps] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= div_valid[NumSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_none <= div_data[NumSteps].none;
            if (div_data[NumSteps].none) begin
                r_out_left  <= fes_pkg::DefaultSpeed;
                r_out_right <= fes_pkg::DefaultSpeed;
            end else begin
                r_out_left  <= div_data[NumSteps].q_l;
                r_out_right <= div_data[NumSteps].q_r;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_right, r_out_left};
    assign o_m_axis_tuser  = r_out_none;

endmodule

// ----- test/tb_fuzzy_edge_follow_speed.sv -----
module tb_fuzzy_edge_follow_speed;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_LATENCY = 15;
    localparam int NUM_RANDOM   = 400;
    localparam int QUIET_FROM   = NUM_RANDOM - 60;   // no idling from here on
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_AT     = 260;
    localparam int NUM_DIRECTED = 24;

    localparam int unsigned MAX_DIST = 999;
    localparam int unsigned Q15_ONE  = 32768;

    // close, ok, far: a, b, c, d
    localparam int unsigned TRAP [3][4] = '{
        '{0,   0,   400,  500},
        '{450, 550, 650,  750},
        '{600, 700, 1000, 1000}
    };

    // [front set][back set]
    localparam fes_pkg::t_speed_set RIGHT_OF [3][3] = '{
        '{fes_pkg::SPD_FAST, fes_pkg::SPD_FAST, fes_pkg::SPD_FAST},
        '{fes_pkg::SPD_NORM, fes_pkg::SPD_NORM, fes_pkg::SPD_NORM},
        '{fes_pkg::SPD_SLOW, fes_pkg::SPD_NORM, fes_pkg::SPD_NORM}
    };
    localparam fes_pkg::t_speed_set LEFT_OF [3][3] = '{
        '{fes_pkg::SPD_NORM, fes_pkg::SPD_NORM, fes_pkg::SPD_SLOW},
        '{fes_pkg::SPD_FAST, fes_pkg::SPD_NORM, fes_pkg::SPD_SLOW},
        '{fes_pkg::SPD_FAST, fes_pkg::SPD_FAST, fes_pkg::SPD_NORM}
    };

    localparam int BREAKS [10] = '{0, 400, 450, 500, 550, 600, 650, 700, 750, 999};

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic       none;
    } t_wheel_speeds;

    typedef struct packed {
        logic [15:0]   front;
        logic [15:0]   back;
        logic          typed;
        t_wheel_speeds want;
    } t_dist_row;

    typedef struct packed {
        logic [15:0]   front;
        logic [15:0]   back;
        t_wheel_speeds want;
    } t_pending;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [31:0] i_s_axis_tdata  = '0;    // front_distance, back_distance
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;          // left_speed, right_speed
    logic        o_m_axis_tuser;          // no_rule_fired

    t_pending speed_q [$];
    int       mismatch_count = 0;
    bit       quiet          = 1'b0;
    bit       hold_req       = 1'b0;

    // typed rows: single-set cases and clamped inputs; untyped rows use predict_speeds
    t_dist_row dist_rows [NUM_DIRECTED] = '{
        '{16'd0,     16'd0,     1'b1, '{8'd100, 8'd150, 1'b0}},
        '{16'd999,   16'd999,   1'b1, '{8'd100, 8'd100, 1'b0}},
        '{16'hFFFF,  16'hFFFF,  1'b1, '{8'd100, 8'd100, 1'b0}},
        '{16'd0,     16'd999,   1'b1, '{8'd50,  8'd150, 1'b0}},
        '{16'd999,   16'd0,     1'b1, '{8'd150, 8'd50,  1'b0}},
        '{16'd1000,  16'hFFFF,  1'b1, '{8'd100, 8'd100, 1'b0}},
        '{16'd400,   16'd400,   1'b1, '{8'd100, 8'd150, 1'b0}},
        '{16'd750,   16'd750,   1'b1, '{8'd100, 8'd100, 1'b0}},
        '{16'hAAAA,  16'h5555,  1'b1, '{8'd100, 8'd100, 1'b0}},
        '{16'h8000,  16'h03E8,  1'b1, '{8'd100, 8'd100, 1'b0}},
        '{16'd550,   16'd650,   1'b0, '0},
        '{16'd450,   16'd500,   1'b0, '0},
        '{16'd500,   16'd450,   1'b0, '0},
        '{16'd600,   16'd700,   1'b0, '0},
        '{16'd700,   16'd600,   1'b0, '0},
        '{16'd401,   16'd499,   1'b0, '0},
        '{16'd499,   16'd401,   1'b0, '0},
        '{16'd451,   16'd549,   1'b0, '0},
        '{16'd651,   16'd749,   1'b0, '0},
        '{16'd601,   16'd699,   1'b0, '0},
        '{16'd475,   16'd625,   1'b0, '0},
        '{16'd1,     16'd998,   1'b0, '0},
        '{16'd998,   16'd1,     1'b0, '0},
        '{16'd525,   16'd675,   1'b0, '0}
    };

    fuzzy_edge_follow_speed dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned trap_grade(input int unsigned x, input int s);
        int unsigned a, b, c, d;
        a = TRAP[s][0];
        b = TRAP[s][1];
        c = TRAP[s][2];
        d = TRAP[s][3];
        if (x < a || x > d) begin
            return 0;
        end
        if (x < b) begin
            return ((x - a) * Q15_ONE) / (b - a);
        end
        if (x <= c) begin
            return Q15_ONE;
        end
        return ((d - x) * Q15_ONE) / (d - c);
    endfunction

    function automatic longint unsigned center_mms(input fes_pkg::t_speed_set s);
        case (s)
            fes_pkg::SPD_SLOW: return 50;
            fes_pkg::SPD_NORM: return 100;
            fes_pkg::SPD_FAST: return 150;
            default:           return 0;
        endcase
    endfunction

    function automatic t_wheel_speeds predict_speeds(input logic [15:0] front_raw,
                                                     input logic [15:0] back_raw);
        int unsigned       fx, bx, w;
        int unsigned       fm [3];
        int unsigned       bm [3];
        longint unsigned   wsum, lnum, rnum;
        t_wheel_speeds     r;
        fx = (front_raw > MAX_DIST) ? MAX_DIST : int'(front_raw);
        bx = (back_raw > MAX_DIST) ? MAX_DIST : int'(back_raw);
        wsum = 0;
        lnum = 0;
        rnum = 0;
        for (int j = 0; j < 3; j++) begin
            fm[j] = trap_grade(fx, j);
            bm[j] = trap_grade(bx, j);
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                w = (fm[j] < bm[k]) ? fm[j] : bm[k];
                wsum += w;
                rnum += w * center_mms(RIGHT_OF[j][k]);
                lnum += w * center_mms(LEFT_OF[j][k]);
            end
        end
        if (wsum == 0) begin
            r.left  = 8'd100;
            r.right = 8'd100;
            r.none  = 1'b1;
        end else begin
            r.left  = 8'(lnum / wsum);
            r.right = 8'(rnum / wsum);
            r.none  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_distance();
        int v;
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                v = int'($urandom_range(0, 65535));
            end
            3, 4, 5, 6: begin
                v = BREAKS[$urandom_range(0, 9)] + int'($urandom_range(0, 4)) - 2;
                if (v < 0) begin
                    v = 0;
                end
            end
            default: begin
                v = int'($urandom_range(0, MAX_DIST));
            end
        endcase
        return 16'(v);
    endfunction

    // one beat in; returns after it was taken
    task automatic send_pair(input logic [15:0] front, input logic [15:0] back,
                             input bit typed, input t_wheel_speeds want);
        t_pending p;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {back, front};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        p.front = front;
        p.back  = back;
        p.want  = typed ? want : predict_speeds(front, back);
        speed_q.push_back(p);
    endtask

    task automatic sender_gap();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= $urandom;
        repeat ($urandom_range(1, 17)) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dist_rows[n]) begin
            send_pair(dist_rows[n].front, dist_rows[n].back, dist_rows[n].typed,
                      dist_rows[n].want);
            if ($urandom_range(0, 3) == 0) begin
                sender_gap();
            end
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == QUIET_FROM) begin
                quiet = 1'b1;
            end
            if (n == HOLD_AT) begin
                hold_req = 1'b1;
            end
            if (n == DRAIN_AT) begin
                i_s_axis_tvalid <= 1'b0;
                while (speed_q.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            // keep offering back to back while the output is held off
            if (!quiet && !hold_req && (n < HOLD_AT || n > HOLD_AT + 40)
                    && $urandom_range(0, 5) == 0) begin
                sender_gap();
            end
            send_pair(pick_distance(), pick_distance(), 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (speed_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * PIPE_LATENCY) begin
            @(posedge i_clk);
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // output side backpressure
    initial begin
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) begin
                    @(posedge i_clk);
                end
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) begin
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (speed_q.size() == 0) begin
                $display("%0t: unexpected beat left=%0d right=%0d none=%0b", $realtime,
                         o_m_axis_tdata[7:0], o_m_axis_tdata[15:8], o_m_axis_tuser);
                mismatch_count++;
            end else begin
                p = speed_q.pop_front();
                if (o_m_axis_tdata[7:0] !== p.want.left) begin
                    $display("%0t: left_speed front=%0d back=%0d expected %0d got %0d",
                             $realtime, p.front, p.back, p.want.left, o_m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[15:8] !== p.want.right) begin
                    $display("%0t: right_speed front=%0d back=%0d expected %0d got %0d",
                             $realtime, p.front, p.back, p.want.right, o_m_axis_tdata[15:8]);
                    mismatch_count++;
                end
                if (o_m_axis_tuser !== p.want.none) begin
                    $display("%0t: no_rule_fired front=%0d back=%0d expected %0b got %0b",
                             $realtime, p.front, p.back, p.want.none, o_m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule
